// ===== src/ndw_pkg.sv =====
package ndw_pkg;

  // Default configuration of the block.
  localparam int ClusterIdsDef = 256;
  localparam int CountBitsDef  = 16;

  // Fixed field widths of the row and result transactions.
  localparam int IdBits     = 8;
  localparam int WeightBits = 16;

  // Result queue geometry.
  localparam int ResDepth   = 4;
  localparam int ResPtrBits = 2;
  localparam int ResOccBits = 3;

endpackage

// ===== src/nd_weight_distinct_count.sv =====
// A weight is pushed into the result queue when its last row is in the second stage.
// Throughput: one row per cycle while the result queue has room; each row reads
// its left id's word from the row memory and writes it back in the next cycle,
// with a one-deep forward register. A four-entry result queue takes weights
// while m_axis stalls. Reset: one valid flip-flop per left id is cleared at once,
// so no clearing pass runs; a last row clears the same valid bits and the maximum.
module nd_weight_distinct_count #(
  parameter int CLUSTER_IDS = ndw_pkg::ClusterIdsDef,
  parameter int COUNT_BITS  = ndw_pkg::CountBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [7:0] lhs_cluster, [15:8] rhs_cluster
  input  logic [2*ndw_pkg::IdBits-1:0]     s_axis_tdata,
  input  logic                             s_axis_tlast,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [15:0] weight
  output logic [ndw_pkg::WeightBits-1:0]   m_axis_tdata
);

  localparam int IdSpan   = (CLUSTER_IDS < 256) ? CLUSTER_IDS : 256;
  localparam int IdxBits  = $clog2(IdSpan);
  localparam int WordBits = IdSpan + COUNT_BITS;
  localparam int CmpBits  = (COUNT_BITS > ndw_pkg::WeightBits) ? COUNT_BITS
                                                                : ndw_pkg::WeightBits;
  localparam logic [COUNT_BITS-1:0]              CountMax  = {COUNT_BITS{1'b1}};
  localparam logic [ndw_pkg::IdBits:0]           SpanLimit = (ndw_pkg::IdBits + 1)'(IdSpan);
  localparam logic [ndw_pkg::ResOccBits-1:0]     QueueCap  =
    ndw_pkg::ResOccBits'(ndw_pkg::ResDepth);

  // Row memory: one word per left id, {count, right id bitmap}.
  logic [WordBits-1:0] mem_q [IdSpan];
  logic [WordBits-1:0] rd_word_q;
  logic [IdxBits-1:0]  rd_addr;
  logic                wr_en;
  logic [WordBits-1:0] wr_word;

  logic [IdSpan-1:0]   row_valid_q, row_valid_d;

  // Second stage of the row pipeline.
  logic                       s1_valid_q;
  logic [ndw_pkg::IdBits-1:0] s1_lhs_q, s1_rhs_q;
  logic                       s1_last_q;

  // Forward register for a write that the memory read missed.
  logic                fwd_valid_q, fwd_valid_d;
  logic [IdxBits-1:0]  fwd_addr_q;
  logic [WordBits-1:0] fwd_word_q;

  logic [COUNT_BITS-1:0] best_q, best_d, best_upd;

  logic                  in_accept;
  logic [IdxBits-1:0]    lhs_idx, rhs_idx;
  logic                  in_range;
  logic [WordBits-1:0]   cur_word;
  logic [IdSpan-1:0]     cur_map, new_map;
  logic [COUNT_BITS-1:0] cur_cnt, new_cnt;
  logic                  bump;

  logic                               res_push;
  logic [ndw_pkg::WeightBits-1:0]     res_data;
  logic [ndw_pkg::ResOccBits-1:0]     res_occ;

  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign rd_addr   = s_axis_tdata[IdxBits-1:0];

  // Room must remain for the row in flight and for the one taken now.
  assign s_axis_tready =
    (res_occ + ndw_pkg::ResOccBits'(s1_valid_q && s1_last_q)) < QueueCap;

  // Synchronous memory with a registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[lhs_idx] <= wr_word;
    end
    rd_word_q <= mem_q[rd_addr];
  end

  // Read-modify-write of the row word for the row in the second stage.
  always_comb begin
    lhs_idx  = s1_lhs_q[IdxBits-1:0];
    rhs_idx  = s1_rhs_q[IdxBits-1:0];
    in_range = (s1_lhs_q != '0) && ({1'b0, s1_lhs_q} < SpanLimit)
               && ({1'b0, s1_rhs_q} < SpanLimit);
    if (fwd_valid_q && (fwd_addr_q == lhs_idx)) begin
      cur_word = fwd_word_q;
    end else if (row_valid_q[lhs_idx]) begin
      cur_word = rd_word_q;
    end else begin
      cur_word = '0;
    end
    cur_map = cur_word[IdSpan-1:0];
    cur_cnt = cur_word[WordBits-1 -: COUNT_BITS];
    new_map = cur_map;
    if (s1_rhs_q != '0) begin
      new_map[rhs_idx] = 1'b1;
    end
    // A unique right value always counts; a known one only when first seen.
    bump    = (s1_rhs_q == '0) || !cur_map[rhs_idx];
    new_cnt = (bump && (cur_cnt != CountMax)) ? cur_cnt + 1'b1 : cur_cnt;
    wr_en   = s1_valid_q && in_range;
    wr_word = {new_cnt, new_map};
  end

  // Running maximum, result and clearing on the last row.
  always_comb begin
    best_upd = (wr_en && (new_cnt > best_q)) ? new_cnt : best_q;
    res_push = s1_valid_q && s1_last_q;
    if (CmpBits'(best_upd) > CmpBits'({ndw_pkg::WeightBits{1'b1}})) begin
      res_data = {ndw_pkg::WeightBits{1'b1}};
    end else begin
      res_data = ndw_pkg::WeightBits'(CmpBits'(best_upd));
    end
    best_d      = res_push ? '0 : best_upd;
    fwd_valid_d = wr_en && !s1_last_q;
    row_valid_d = row_valid_q;
    if (res_push) begin
      row_valid_d = '0;
    end else if (wr_en) begin
      row_valid_d[lhs_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      row_valid_q <= '0;
      best_q      <= '0;
    end else begin
      s1_valid_q  <= in_accept;
      fwd_valid_q <= fwd_valid_d;
      row_valid_q <= row_valid_d;
      best_q      <= best_d;
    end
  end

  // Row payload and forward data need no reset.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_lhs_q  <= s_axis_tdata[ndw_pkg::IdBits-1:0];
      s1_rhs_q  <= s_axis_tdata[2*ndw_pkg::IdBits-1:ndw_pkg::IdBits];
      s1_last_q <= s_axis_tlast;
    end
    fwd_addr_q <= lhs_idx;
    fwd_word_q <= wr_word;
  end

  // Result queue towards the master side.
  ndw_res_fifo u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_push),
    .push_data_i (res_data),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .data_o      (m_axis_tdata),
    .occ_o       (res_occ)
  );

`ifndef ASSERT_OFF
  // A result is never pushed into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> (res_occ != QueueCap))
    else $error("result pushed into full queue");

  // A last row leaves the maximum cleared and nothing to forward.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_last_q) |=> ((best_q == '0) && !fwd_valid_q))
    else $error("pair state not cleared after last row");

  // Within a pair the maximum never falls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_last_q) |=> (best_q >= $past(best_q)))
    else $error("running maximum decreased");

  // Every accepted row reaches the second stage in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> s1_valid_q)
    else $error("accepted row lost before second stage");
`endif

endmodule

// ===== src/ndw_res_fifo.sv =====
module ndw_res_fifo (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push_i,
  input  logic [ndw_pkg::WeightBits-1:0]      push_data_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output logic [ndw_pkg::WeightBits-1:0]      data_o,
  output logic [ndw_pkg::ResOccBits-1:0]      occ_o
);

  logic [ndw_pkg::WeightBits-1:0] entry_q [ndw_pkg::ResDepth];
  logic [ndw_pkg::ResPtrBits-1:0] wr_ptr_q, wr_ptr_d;
  logic [ndw_pkg::ResPtrBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [ndw_pkg::ResOccBits-1:0] occ_q, occ_d;
  logic                           pop;

  // The head entry is shown whenever the queue holds a result.
  assign valid_o = (occ_q != '0);
  assign data_o  = entry_q[rd_ptr_q];
  assign occ_o   = occ_q;
  assign pop     = valid_o && ready_i;

  // Pointer and occupancy updates for push and pop in the same cycle.
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    occ_d    = occ_q + ndw_pkg::ResOccBits'(push_i) - ndw_pkg::ResOccBits'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      occ_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      occ_q    <= occ_d;
    end
  end

  // Result storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== sim/tb_nd_weight_distinct_count.sv =====
`timescale 1ns / 1ps

module tb_nd_weight_distinct_count;

  localparam int IdBits     = ndw_pkg::IdBits;
  localparam int WeightBits = ndw_pkg::WeightBits;
  localparam int ClusterIds = ndw_pkg::ClusterIdsDef;
  localparam int CountBits  = ndw_pkg::CountBitsDef;
  localparam int IdSpan     = (ClusterIds < 256) ? ClusterIds : 256;
  localparam longint unsigned CountMax   = (64'd1 << CountBits) - 64'd1;
  localparam longint unsigned WeightMax  = (64'd1 << WeightBits) - 64'd1;

  // A cluster id of zero marks a value that occurs only once in its column.
  localparam logic [IdBits-1:0] UniqueId = '0;

  // Pacing of the stimulus and of the stalls on the result side.
  localparam int RandomRows    = 370;
  localparam int HoldAfterRows = 200;
  localparam int HoldCycles    = 400;
  localparam int IdleLimit     = 2000;
  localparam int SettleCycles  = 8;

  typedef logic [IdBits-1:0]     id_t;
  typedef logic [WeightBits-1:0] weight_t;

  typedef struct {
    id_t  lhs;
    id_t  rhs;
    logic last;
  } row_t;

  typedef enum logic [1:0] {
    RxFree,
    RxPatchy,
    RxChoked
  } rx_mode_e;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [2*IdBits-1:0]  s_axis_tdata  = '0;
  logic                 s_axis_tlast  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [WeightBits-1:0] m_axis_tdata;

  // Rows waiting to be offered, and weights waiting to come back.
  row_t    rows_pending[$];
  weight_t weights_due[$];

  // Shadow of the block's pair bitmap, per-key counts and running maximum.
  bit [255:0]       seen_pairs[256];
  longint unsigned  key_tally[256];
  longint unsigned  best_tally;

  int       rows_taken    = 0;
  int       weights_seen  = 0;
  int       fail_count    = 0;
  int       quiet_cycles  = 0;
  int       gap_left      = 0;
  int       burst_left    = 0;
  rx_mode_e rx_mode       = RxFree;
  int       mode_left     = 0;
  int       hold_left     = 0;
  bit       hold_done     = 1'b0;

  nd_weight_distinct_count #(
    .CLUSTER_IDS(ClusterIds),
    .COUNT_BITS (CountBits)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Fold one accepted row into the shadow state; a last row yields the weight.
  task automatic absorb_row(input id_t lhs, input id_t rhs, input logic last);
    bit      bump;
    weight_t due;
    if (lhs != UniqueId && lhs < IdSpan && rhs < IdSpan) begin
      if (rhs == UniqueId) begin
        bump = 1'b1;
      end else begin
        bump = !seen_pairs[lhs][rhs];
        seen_pairs[lhs][rhs] = 1'b1;
      end
      if (bump && key_tally[lhs] < CountMax) key_tally[lhs]++;
      if (key_tally[lhs] > best_tally) best_tally = key_tally[lhs];
    end
    if (last) begin
      due = (best_tally > WeightMax) ? weight_t'(WeightMax) : weight_t'(best_tally);
      weights_due = {weights_due, due};
      foreach (seen_pairs[k]) seen_pairs[k] = '0;
      foreach (key_tally[k]) key_tally[k] = 0;
      best_tally = 0;
    end
  endtask

  // Predict on every input transaction.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      absorb_row(s_axis_tdata[IdBits-1:0], s_axis_tdata[2*IdBits-1:IdBits], s_axis_tlast);
      rows_taken <= rows_taken + 1;
    end
  end

  // Row driver: bursts of random length separated by random gaps.
  always @(posedge clk_i or negedge rst_ni) begin : row_driver
    row_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
      gap_left      <= 0;
      burst_left    <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left != 0) begin
        s_axis_tvalid <= 1'b0;
        gap_left      <= gap_left - 1;
      end else if (rows_pending.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else begin
        nxt = rows_pending.pop_front();
        s_axis_tdata  <= {nxt.rhs, nxt.lhs};
        s_axis_tlast  <= nxt.last;
        s_axis_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 32);
          if ($urandom_range(0, 2) == 0) gap_left <= 0;
          else gap_left <= $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Result receiver: its own stall pattern, plus one long hold-off.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_mode       <= RxFree;
      mode_left     <= 0;
      hold_left     <= 0;
      hold_done     <= 1'b0;
    end else if (!hold_done && rows_taken >= HoldAfterRows) begin
      hold_done     <= 1'b1;
      hold_left     <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RxFree:   m_axis_tready <= 1'b1;
        RxPatchy: m_axis_tready <= ($urandom_range(0, 3) != 0);
        default:  m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
      if (mode_left == 0) begin
        rx_mode   <= rx_mode_e'($urandom_range(0, 2));
        mode_left <= $urandom_range(8, 64);
      end else begin
        mode_left <= mode_left - 1;
      end
    end
  end

  // Compare each output transaction with the oldest predicted weight.
  always @(posedge clk_i) begin : weight_monitor
    weight_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      weights_seen <= weights_seen + 1;
      if (weights_due.size() == 0) begin
        $error("weight: none expected, actual %0d", m_axis_tdata);
        fail_count <= fail_count + 1;
      end else begin
        want = weights_due.pop_front();
        if (m_axis_tdata !== want) begin
          $error("weight: expected %0d, actual %0d", want, m_axis_tdata);
          fail_count <= fail_count + 1;
        end
      end
    end
  end

  // Watchdog on cycles in which neither side moves a transaction.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("nd_weight_distinct_count test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_row(input id_t lhs, input id_t rhs, input logic last);
    row_t r;
    r.lhs  = lhs;
    r.rhs  = rhs;
    r.last = last;
    rows_pending = {rows_pending, r};
  endtask

  // Hold the sender back until every row has gone and every weight has returned.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (rows_pending.size() != 0 || s_axis_tvalid || weights_due.size() != 0);
  endtask

  // Column pairs of random length; a few hot left keys per pair so that counts grow.
  task automatic queue_random_pairs(input int rows);
    int  left;
    int  len;
    id_t hot[4];
    id_t lhs;
    id_t rhs;
    left = rows;
    while (left > 0) begin
      len = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 24);
      if (len > left) len = left;
      foreach (hot[k]) begin
        if ($urandom_range(0, 15) == 0) hot[k] = id_t'($urandom_range(0, 255));
        else hot[k] = id_t'($urandom_range(1, 255));
      end
      for (int r = 0; r < len; r++) begin
        case ($urandom_range(0, 9))
          0:       lhs = UniqueId;
          1:       lhs = id_t'($urandom_range(0, 255));
          default: lhs = hot[$urandom_range(0, 3)];
        endcase
        case ($urandom_range(0, 7))
          0, 1:    rhs = UniqueId;
          2:       rhs = id_t'($urandom_range(0, 255));
          default: rhs = id_t'($urandom_range(1, 6));
        endcase
        queue_row(lhs, rhs, r == len - 1);
      end
      left -= len;
    end
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Empty pair: only a unique left value before the last mark.
    queue_row(UniqueId, 8'd9, 1'b1);
    // Extreme ids, repeated pairs, unique right values and a skipped unique left row.
    queue_row(8'd255, 8'd255, 1'b0);
    queue_row(8'd255, 8'd255, 1'b0);
    queue_row(8'd255, UniqueId, 1'b0);
    queue_row(8'd255, UniqueId, 1'b0);
    queue_row(8'd255, 8'd1, 1'b0);
    queue_row(8'd1, 8'd255, 1'b0);
    queue_row(UniqueId, 8'd255, 1'b0);
    queue_row(8'd128, 8'd170, 1'b1);
    // Alternating bit patterns on both ids.
    queue_row(8'h55, 8'hAA, 1'b0);
    queue_row(8'hAA, 8'h55, 1'b0);
    queue_row(8'h55, 8'h55, 1'b0);
    queue_row(8'hAA, 8'hAA, 1'b1);
    // Last mark on a skipped row still emits what came before.
    queue_row(8'd5, 8'd5, 1'b0);
    queue_row(8'd5, 8'd6, 1'b0);
    queue_row(UniqueId, 8'd3, 1'b1);
    // Back-to-back single-row pairs: each must start from a cleared bitmap.
    queue_row(8'd1, 8'd1, 1'b1);
    queue_row(8'd2, UniqueId, 1'b1);
    queue_row(8'd1, 8'd1, 1'b1);
    wait_drained();

    // Random pairs; the long result hold-off falls inside this phase.
    queue_random_pairs(RandomRows);
    wait_drained();
    queue_random_pairs(RandomRows);
    wait_drained();
    repeat (SettleCycles) @(negedge clk_i);

    $display("Run covered %0d rows and %0d column-pair weights: directed edge rows,",
             rows_taken, weights_seen);
    $display("random pairs under sender gaps, receiver stalls and one long hold-off.");
    if (fail_count == 0) begin
      $display("nd_weight_distinct_count test passed");
    end else begin
      $display("nd_weight_distinct_count test failed");
    end
    $finish;
  end

endmodule
